[rtl/wtcr_pkg.sv]
// ----------------------------------------------------------------------------
// wtcr_pkg
// Shared types and constants for the window table / cursor router.
// ----------------------------------------------------------------------------
`default_nettype none

package wtcr_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] CMD_MOUSE   = 2'd0;
    localparam logic [1:0] CMD_CREATE  = 2'd1;
    localparam logic [1:0] CMD_COMMIT  = 2'd2;
    localparam logic [1:0] CMD_DESTROY = 2'd3;

    localparam logic [1:0] RK_CREATE = 2'd0;
    localparam logic [1:0] RK_CLOSED = 2'd1;
    localparam logic [1:0] RK_ROUTED = 2'd2;
    localparam logic [1:0] RK_CURSOR = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EXISTS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam logic [11:0] CUR_X_RST  = 12'd320;
    localparam logic [11:0] CUR_Y_RST  = 12'd240;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        requester_id;
        logic [11:0]        req_width;
        logic [11:0]        req_height;
        logic               fullscreen_flag;
        logic [15:0]        target_window;
        logic               is_move;
        logic [7:0]         mouse_event_kind;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [7:0]         button_bits;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status;
        logic [15:0] window_id_out;
        logic [11:0] granted_width;
        logic [11:0] granted_height;
        logic [15:0] dest_owner;
        logic [11:0] local_x;
        logic [11:0] local_y;
        logic [7:0]  buttons_out;
        logic [7:0]  event_kind_out;
        logic        redraw_needed;
    } result_t;

    // front-end classified item handed to the slot engine
    typedef struct packed {
        item_t       item;
        logic        fs;
        logic [11:0] cur_x;
        logic [11:0] cur_y;
        logic        moved;
    } job_t;

    function automatic logic [11:0] clamp_axis(input logic [11:0] cur,
                                               input logic signed [15:0] delta,
                                               input logic [11:0] size);
        logic signed [17:0] p;
        logic signed [17:0] lim;
        begin
            lim = (size == 12'd0) ? 18'sd0 : $signed({6'd0, size}) - 18'sd1;
            p   = $signed({6'd0, cur}) + 18'(delta);
            if (p < 18'sd0)
            begin
                p = 18'sd0;
            end
            if (p > lim)
            begin
                p = lim;
            end
            return p[11:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/wtcr_front.sv]
// ----------------------------------------------------------------------------
// wtcr_front
// Takes commands, applies cursor moves, decides fullscreen, pushes a job.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wtcr_pkg::item_t      item,
    output logic                 busy,
    input  wire logic [11:0]     scr_w,
    input  wire logic [11:0]     scr_h,
    output logic                 job_valid,
    output wtcr_pkg::job_t       job,
    input  wire logic            job_pop
);
    import wtcr_pkg::*;

    // two-entry queue
    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic [11:0] cx_reg;
    logic [11:0] cy_reg;
    logic       push;
    logic [11:0] nx;
    logic [11:0] ny;
    job_t       nj;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rd_reg];

    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        if (item.command == CMD_MOUSE && item.is_move)
        begin
            nx = clamp_axis(cx_reg, item.delta_x, scr_w);
            ny = clamp_axis(cy_reg, item.delta_y, scr_h);
        end
        nj.item  = item;
        nj.fs    = item.fullscreen_flag || item.req_width == 12'd0 ||
                   item.req_height == 12'd0;
        nj.cur_x = nx;
        nj.cur_y = ny;
        nj.moved = (item.command == CMD_MOUSE) && item.is_move;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= nj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cx_reg  <= CUR_X_RST;
            cy_reg  <= CUR_Y_RST;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
                cx_reg <= nx;
                cy_reg <= ny;
            end
            if (job_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, job_pop};
        end
    end

endmodule

`default_nettype wire

[rtl/wtcr_back.sv]
// ----------------------------------------------------------------------------
// wtcr_back
// Slot table engine: scans the slots one per cycle and issues the result, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcr_back #(
    parameter int SLOTS = wtcr_pkg::SLOTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wtcr_pkg::job_t       job,
    output logic                 job_pop,
    input  wire logic [11:0]     scr_w,
    input  wire logic [11:0]     scr_h,
    output logic                 result_valid,
    output wtcr_pkg::result_t    result
);
    import wtcr_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [SLOTS-1:0] act_reg;
    logic [15:0]      wid_reg [SLOTS];
    logic [15:0]      own_reg [SLOTS];
    logic [11:0]      sw_reg  [SLOTS];
    logic [11:0]      sh_reg  [SLOTS];
    logic [15:0]      nid_reg;
    logic             pend_reg;
    logic [1:0]       st_reg;
    logic [SW-1:0]    idx_reg;
    logic             found_reg;
    logic [SW-1:0]    fidx_reg;
    logic             exists_reg;
    logic             free_reg;
    logic [SW-1:0]    free_idx_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             rv_reg;

    logic [SW-1:0] ix;
    logic          match;
    logic          lastc;
    logic          dn;
    logic          mouse;

    assign mouse = (job.item.command == CMD_MOUSE);
    // mouse scans high to low, others low to high
    assign ix = mouse ? (LAST - idx_reg) : idx_reg;
    assign lastc = (idx_reg == LAST);

    always_comb
    begin
        match = 1'b0;
        case (job.item.command)
            CMD_MOUSE:  match = act_reg[ix] && job.cur_x < sw_reg[ix] &&
                                job.cur_y < sh_reg[ix];
            default:    match = act_reg[ix] && wid_reg[ix] == job.item.target_window;
        endcase
    end

    assign dn = (st_reg == S_SCAN) && (lastc || (match && !found_reg &&
                 job.item.command != CMD_CREATE));
    assign job_pop = (st_reg == S_DONE);
    assign result_valid = rv_reg;
    assign result = res_reg;

    always_comb
    begin
        res_next = '0;
        res_next.redraw_needed = pend_reg || job.moved ||
            (job.item.command == CMD_DESTROY && found_reg);
        unique case (job.item.command)
            CMD_MOUSE:
            begin
                res_next.result_kind    = found_reg ? RK_ROUTED : RK_CURSOR;
                res_next.window_id_out  = found_reg ? wid_reg[fidx_reg] : 16'd0;
                res_next.dest_owner     = found_reg ? own_reg[fidx_reg] : 16'd0;
                res_next.local_x        = job.cur_x;
                res_next.local_y        = job.cur_y;
                res_next.buttons_out    = job.item.button_bits;
                res_next.event_kind_out = job.item.mouse_event_kind;
            end
            CMD_CREATE:
            begin
                res_next.result_kind = RK_CREATE;
                res_next.dest_owner  = job.item.requester_id;
                if (exists_reg)
                begin
                    res_next.status = ST_EXISTS;
                end
                else if (!free_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    res_next.status         = ST_OK;
                    res_next.window_id_out  = nid_reg;
                    res_next.granted_width  = job.fs ? scr_w : job.item.req_width;
                    res_next.granted_height = job.fs ? scr_h : job.item.req_height;
                end
            end
            default:
            begin
                res_next.result_kind   = RK_CLOSED;
                res_next.window_id_out = job.item.target_window;
                res_next.dest_owner    = own_reg[fidx_reg];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_DONE && job.item.command == CMD_CREATE && !exists_reg &&
            free_reg)
        begin
            wid_reg[free_idx_reg] <= nid_reg;
            own_reg[free_idx_reg] <= job.item.requester_id;
            sw_reg[free_idx_reg]  <= job.fs ? scr_w : job.item.req_width;
            sh_reg[free_idx_reg]  <= job.fs ? scr_h : job.item.req_height;
        end
        if (st_reg == S_DONE)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= '0;
            nid_reg      <= 16'd1;
            pend_reg     <= 1'b0;
            st_reg       <= S_IDLE;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            exists_reg   <= 1'b0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            // commit never answers; destroy answers only when the id was found
            rv_reg <= (st_reg == S_DONE) && (job.item.command != CMD_COMMIT) &&
                      (job.item.command != CMD_DESTROY || found_reg);
            unique case (st_reg)
                S_IDLE:
                begin
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    exists_reg <= 1'b0;
                    free_reg   <= 1'b0;
                    if (job_valid)
                    begin
                        st_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (job.item.command == CMD_CREATE)
                    begin
                        if (act_reg[ix] && own_reg[ix] == job.item.requester_id)
                        begin
                            exists_reg <= 1'b1;
                        end
                        if (!act_reg[ix] && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= ix;
                        end
                    end
                    else if (match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= ix;
                    end
                    idx_reg <= idx_reg + SW'(1);
                    if (dn)
                    begin
                        st_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    st_reg <= S_IDLE;
                    unique case (job.item.command)
                        CMD_MOUSE:
                        begin
                            pend_reg <= 1'b0;
                        end
                        CMD_CREATE:
                        begin
                            pend_reg <= 1'b0;
                            if (!exists_reg && free_reg)
                            begin
                                act_reg[free_idx_reg] <= 1'b1;
                                nid_reg <= nid_reg + 16'd1;
                            end
                        end
                        CMD_COMMIT:
                        begin
                            if (found_reg)
                            begin
                                pend_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            if (found_reg)
                            begin
                                pend_reg <= 1'b0;
                                act_reg[fidx_reg] <= 1'b0;
                            end
                        end
                    endcase
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/window_table_cursor_router.sv]
// ----------------------------------------------------------------------------
// window_table_cursor_router
// Window slot table with cursor tracking and mouse event routing.
//
//  channel | signals                        | direction
//  cmd     | start, busy, cmd               | in
//  result  | result_valid, result           | out (one-cycle strobe)
//  cfg     | cfg_valid, cfg_ready, cfg_*    | in
//
// The back end handles an item in steps: the idle state picks it up, the scan
// state checks up to SLOTS slots one slot per cycle, and the done state issues.
// A two-entry queue lets the front accept while the back end scans.
// Reset clears slot valid bits, sets the id counter to 1 and recentres the cursor.
// Results cannot be stalled; busy rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module window_table_cursor_router #(
    parameter int SLOTS = wtcr_pkg::SLOTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wtcr_pkg::item_t      cmd,
    output logic                 result_valid,
    output wtcr_pkg::result_t    result,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire logic [11:0]     cfg_data
);
    import wtcr_pkg::*;

    logic [11:0] w_reg;
    logic [11:0] h_reg;
    logic        jv;
    logic        jp;
    job_t        jb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WIDTH_RST;
            h_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  w_reg <= cfg_data;
                default:    h_reg <= cfg_data;
            endcase
        end
    end

    wtcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (cmd),
        .busy      (busy),
        .scr_w     (w_reg),
        .scr_h     (h_reg),
        .job_valid (jv),
        .job       (jb),
        .job_pop   (jp)
    );

    wtcr_back #(.SLOTS(SLOTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (jv),
        .job          (jb),
        .job_pop      (jp),
        .scr_w        (w_reg),
        .scr_h        (h_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for window_table_cursor_router: a cycle-free predictor
// of the slot table and cursor forecasts each reply, closed notice and routed
// mouse transaction; results are compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import wtcr_pkg::*;

    localparam int  NSLOT      = 16;
    localparam int  DRAIN_CYC  = 4 * (NSLOT + 3);
    localparam int  CYCLE_CAP  = 400000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   cmd;
    logic    result_valid;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_index;
    logic [11:0] cfg_data;

    window_table_cursor_router u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    bit          win_live  [NSLOT];
    logic [15:0] win_id    [NSLOT];
    logic [15:0] win_owner [NSLOT];
    logic [11:0] win_w     [NSLOT];
    logic [11:0] win_h     [NSLOT];
    bit          win_dirty [NSLOT];
    logic [15:0] id_next;
    logic [11:0] cur_x;
    logic [11:0] cur_y;
    bit          redraw_pend;
    logic [11:0] scr_w;
    logic [11:0] scr_h;

    result_t     pending_results[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          idle_pct;
    longint      cycles = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [11:0] clamp_pos(logic [11:0] cur, logic signed [15:0] d,
                                              logic [11:0] size);
        int lim;
        int p;
        lim = (size > 0) ? int'(size) - 1 : 0;
        p   = int'(cur) + int'(d);
        if (p < 0)
        begin
            p = 0;
        end
        if (p > lim)
        begin
            p = lim;
        end
        return p[11:0];
    endfunction

    function automatic int slot_of_id(logic [15:0] id);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (win_live[i] && win_id[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // applies one accepted transaction to the table and queues its result, if any
    function automatic void window_table_step(item_t it);
        result_t r;
        int      s;
        int      hit;
        bit      owned;
        bit      emit;
        bit      fs;
        r    = '0;
        emit = 1'b1;
        case (it.command)
            CMD_MOUSE:
            begin
                hit = -1;
                if (it.is_move)
                begin
                    cur_x = clamp_pos(cur_x, it.delta_x, scr_w);
                    cur_y = clamp_pos(cur_y, it.delta_y, scr_h);
                    redraw_pend = 1'b1;
                end
                for (int i = NSLOT - 1; i >= 0; i--)
                begin
                    if (hit < 0 && win_live[i] && cur_x < win_w[i] && cur_y < win_h[i])
                    begin
                        hit = i;
                    end
                end
                r.local_x        = cur_x;
                r.local_y        = cur_y;
                r.buttons_out    = it.button_bits;
                r.event_kind_out = it.mouse_event_kind;
                if (hit >= 0)
                begin
                    r.result_kind   = RK_ROUTED;
                    r.window_id_out = win_id[hit];
                    r.dest_owner    = win_owner[hit];
                end
                else
                begin
                    r.result_kind = RK_CURSOR;
                end
            end
            CMD_CREATE:
            begin
                owned = 1'b0;
                s     = -1;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (win_live[i] && win_owner[i] == it.requester_id)
                    begin
                        owned = 1'b1;
                    end
                    if (s < 0 && !win_live[i])
                    begin
                        s = i;
                    end
                end
                r.result_kind = RK_CREATE;
                r.dest_owner  = it.requester_id;
                if (owned)
                begin
                    r.status = ST_EXISTS;
                end
                else if (s < 0)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    fs = it.fullscreen_flag || it.req_width == 0 || it.req_height == 0;
                    win_live[s]  = 1'b1;
                    win_id[s]    = id_next;
                    win_owner[s] = it.requester_id;
                    win_w[s]     = fs ? scr_w : it.req_width;
                    win_h[s]     = fs ? scr_h : it.req_height;
                    win_dirty[s] = 1'b0;
                    id_next      = id_next + 16'd1;
                    r.status         = ST_OK;
                    r.window_id_out  = win_id[s];
                    r.granted_width  = win_w[s];
                    r.granted_height = win_h[s];
                end
            end
            CMD_COMMIT:
            begin
                emit = 1'b0;
                s = slot_of_id(it.target_window);
                if (s >= 0)
                begin
                    win_dirty[s] = 1'b1;
                    redraw_pend  = 1'b1;
                end
            end
            default:
            begin
                s = slot_of_id(it.target_window);
                if (s < 0)
                begin
                    emit = 1'b0;
                end
                else
                begin
                    win_live[s]  = 1'b0;
                    win_dirty[s] = 1'b0;
                    redraw_pend  = 1'b1;
                    r.result_kind   = RK_CLOSED;
                    r.window_id_out = it.target_window;
                    r.dest_owner    = win_owner[s];
                end
            end
        endcase
        if (emit)
        begin
            // composite pass runs with every emitted result
            r.redraw_needed = redraw_pend;
            redraw_pend = 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                win_dirty[i] = 1'b0;
            end
            pending_results.push_back(r);
        end
    endfunction

    task automatic field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %p", $time, result);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                field_check("result_kind", e.result_kind, result.result_kind);
                field_check("status", e.status, result.status);
                field_check("window_id_out", e.window_id_out, result.window_id_out);
                field_check("granted_width", e.granted_width, result.granted_width);
                field_check("granted_height", e.granted_height, result.granted_height);
                field_check("dest_owner", e.dest_owner, result.dest_owner);
                field_check("local_x", e.local_x, result.local_x);
                field_check("local_y", e.local_y, result.local_y);
                field_check("buttons_out", e.buttons_out, result.buttons_out);
                field_check("event_kind_out", e.event_kind_out, result.event_kind_out);
                field_check("redraw_needed", e.redraw_needed, result.redraw_needed);
            end
        end
    end

    // one transaction; start stays high so back-to-back items need no toggle
    task automatic send_item(item_t it);
        start <= 1'b1;
        cmd   <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        window_table_step(it);
        n_items++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH)
        begin
            scr_w = val;
        end
        else
        begin
            scr_h = val;
        end
    endtask

    function automatic item_t mk_mouse(bit mv, int dx, int dy);
        item_t it;
        it = '0;
        it.command          = CMD_MOUSE;
        it.is_move          = mv;
        it.delta_x          = dx[15:0];
        it.delta_y          = dy[15:0];
        it.mouse_event_kind = 8'($urandom_range(255));
        it.button_bits      = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic item_t mk_create(logic [15:0] owner, int w, int h, bit fs);
        item_t it;
        it = '0;
        it.command         = CMD_CREATE;
        it.requester_id    = owner;
        it.req_width       = w[11:0];
        it.req_height      = h[11:0];
        it.fullscreen_flag = fs;
        return it;
    endfunction

    function automatic item_t mk_target(logic [1:0] c, logic [15:0] id);
        item_t it;
        it = '0;
        it.command       = c;
        it.target_window = id;
        return it;
    endfunction

    function automatic logic [15:0] pick_id();
        int live[$];
        for (int i = 0; i < NSLOT; i++)
        begin
            if (win_live[i])
            begin
                live.push_back(i);
            end
        end
        if (live.size() == 0 || $urandom_range(9) < 3)
        begin
            return 16'($urandom_range(65535));
        end
        return win_id[live[$urandom_range(live.size() - 1)]];
    endfunction

    // random item: mostly a small owner pool so duplicates and a full table occur
    function automatic item_t mk_random();
        item_t it;
        int    sel;
        int    w;
        int    h;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            if ($urandom_range(3) == 0)
            begin
                it = mk_mouse($urandom_range(1), $urandom_range(65535), $urandom_range(65535));
            end
            else
            begin
                it = mk_mouse($urandom_range(1), $urandom_range(400) - 200,
                              $urandom_range(400) - 200);
            end
        end
        else if (sel < 65)
        begin
            w = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(500);
            h = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(500);
            it = mk_create(16'(($urandom_range(7) == 0) ? $urandom_range(65535) :
                                                          $urandom_range(24)),
                           w, h, $urandom_range(5) == 0);
        end
        else if (sel < 80)
        begin
            it = mk_target(CMD_COMMIT, pick_id());
        end
        else
        begin
            it = mk_target(CMD_DESTROY, pick_id());
        end
        // requester_id outside creates, and button_bits, carry noise too
        if ($urandom_range(3) == 0)
        begin
            it.requester_id = (it.command == CMD_CREATE) ? it.requester_id :
                                                           16'($urandom_range(65535));
            it.button_bits  = 8'($urandom_range(255));
        end
        return it;
    endfunction

    task automatic test_basic_ops;
        send_item(mk_mouse(1'b0, 0, 0));
        send_item(mk_mouse(1'b1, 32767, 32767));
        send_item(mk_mouse(1'b1, -32768, -32768));
        send_item(mk_create(16'd1, 100, 50, 1'b0));
        send_item(mk_create(16'd1, 20, 20, 1'b0));
        send_item(mk_create(16'd2, 4095, 4095, 1'b1));
        send_item(mk_create(16'd3, 0, 10, 1'b0));
        send_item(mk_create(16'hFFFF, 10, 0, 1'b0));
        send_item(mk_target(CMD_COMMIT, 16'd1));
        send_item(mk_target(CMD_COMMIT, 16'd999));
        send_item(mk_mouse(1'b0, 0, 0));
        send_item(mk_target(CMD_DESTROY, 16'd1));
        send_item(mk_target(CMD_DESTROY, 16'd1));
        send_item(mk_mouse(1'b1, 50, 20));
    endtask

    task automatic test_table_full;
        for (int i = 0; i < NSLOT - 2; i++)
        begin
            send_item(mk_create(16'(100 + i), 1 + i, 1 + i, 1'b0));
        end
        send_item(mk_create(16'd500, 5, 5, 1'b0));
        send_item(mk_mouse(1'b1, -1000, -1000));
    endtask

    task automatic test_screen_regs;
        drain();
        write_reg(CFG_WIDTH, 12'd0);
        write_reg(CFG_HEIGHT, 12'd0);
        send_item(mk_mouse(1'b1, 300, 300));
        drain();
        write_reg(CFG_WIDTH, 12'd4095);
        write_reg(CFG_HEIGHT, 12'd4095);
        send_item(mk_mouse(1'b1, 32767, 32767));
        send_item(mk_target(CMD_DESTROY, 16'd2));
        send_item(mk_create(16'd2, 0, 0, 1'b0));
        drain();
        write_reg(CFG_WIDTH, 12'd1);
        write_reg(CFG_HEIGHT, 12'd1);
        send_item(mk_mouse(1'b1, 5, 5));
    endtask

    task automatic test_random(int count, int pct, logic [11:0] w, logic [11:0] h);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        idle_pct = pct;
        repeat (count) send_item(mk_random());
    endtask

    // empty the table, then reopen windows and close one repeatedly
    task automatic test_recreate;
        logic [15:0] keep_id;
        idle_pct = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (win_live[i])
            begin
                send_item(mk_target(CMD_DESTROY, win_id[i]));
            end
        end
        keep_id = id_next;
        send_item(mk_create(16'hAAAA, 30, 30, 1'b0));
        send_item(mk_create(16'h5555, 8, 8, 1'b0));
        send_item(mk_target(CMD_COMMIT, keep_id));
        send_item(mk_mouse(1'b1, -4000, -4000));
        send_item(mk_target(CMD_DESTROY, keep_id));
        send_item(mk_target(CMD_DESTROY, keep_id));
        send_item(mk_target(CMD_DESTROY, keep_id));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        errors    = 0;
        n_items   = 0;
        n_results = 0;
        idle_pct  = 20;
        for (int i = 0; i < NSLOT; i++)
        begin
            win_live[i]  = 1'b0;
            win_dirty[i] = 1'b0;
        end
        id_next     = 16'd1;
        cur_x       = CUR_X_RST;
        cur_y       = CUR_Y_RST;
        redraw_pend = 1'b0;
        scr_w       = WIDTH_RST;
        scr_h       = HEIGHT_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_table_full();
        test_screen_regs();
        test_random(330, 20, 12'($urandom_range(1, 4094)), 12'($urandom_range(1, 4094)));
        test_random(330, 88, 12'd640, 12'd480);
        test_random(330, 0, 12'd200, 12'd4095);
        test_recreate();
        drain();

        $display("%0d transactions sent, %0d results checked, %0d errors", n_items,
                 n_results, errors);
        $display("covered: create/exists/full, commit, destroy, routing, clamps, reopen");
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

[window_table_cursor_router.f]
rtl/wtcr_pkg.sv
rtl/wtcr_front.sv
rtl/wtcr_back.sv
rtl/window_table_cursor_router.sv
tb/sv/tb_top.sv
